// ===== rtl/core/bqf_pkg.sv =====
// Shared widths, register indexes and controller/datapath interface types for the biquad filter.
`default_nettype none

package bqf_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS = 17;
	localparam int STATE_BITS = 36;

	localparam int COEF_FRAC = COEF_BITS - 3;
	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS = ((STATE_BITS > PROD_BITS) ? STATE_BITS : PROD_BITS) + 2;
	localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = COEF_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_B0 = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_B1 = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_B2 = CFG_INDEX_BITS'(3);
	localparam logic [CFG_INDEX_BITS-1:0] REG_A1 = CFG_INDEX_BITS'(4);
	localparam logic [CFG_INDEX_BITS-1:0] REG_A2 = CFG_INDEX_BITS'(5);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_B0,
		OP_Y,
		OP_N1A,
		OP_N1B,
		OP_N2A,
		OP_N2B,
		OP_PUSH
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic filter_en;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bqf_datapath.sv =====
// Datapath of the biquad filter: coefficient registers, shared multiplier, delay states.
`default_nettype none

module bqf_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bqf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bqf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic [bqf_pkg::SAMPLE_BITS-1:0]    in_sample,
	input  wire logic                            in_last,
	input  wire bqf_pkg::dp_cmd_t                cmd,
	output bqf_pkg::dp_stat_t                    stat,
	output logic [bqf_pkg::TDATA_BITS-1:0]       out_tdata,
	output logic                                 out_tlast
);
	import bqf_pkg::*;

	localparam logic signed [ACC_BITS-1:0] Y_MAX =
		{{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] Y_MIN = ~Y_MAX;
	localparam logic signed [ACC_BITS-1:0] S_MAX =
		{{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] S_MIN = ~S_MAX;
	localparam logic signed [ACC_BITS-1:0] Y_RND = ACC_BITS'(1) << (COEF_FRAC - 1);

	logic                          enable_q;
	logic signed [COEF_BITS-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [STATE_BITS-1:0]  d1_q, d2_q;
	logic signed [SAMPLE_BITS-1:0] x_q, y_q, out_q;
	logic                          last_q, out_last_q;
	logic signed [PROD_BITS-1:0]   prod_q, mul_res;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [COEF_BITS-1:0]   mul_coef;
	logic signed [SAMPLE_BITS-1:0] mul_val;
	logic signed [ACC_BITS-1:0]    y_sum, y_shift, st_diff;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [STATE_BITS-1:0]  st_sat;

	// One multiplier is shared by all five products; the controller picks the pair.
	always_comb begin
		mul_coef = '0;
		mul_val = '0;
		case (cmd.op)
			OP_B0: begin
				mul_coef = b0_q;
				mul_val = x_q;
			end
			OP_Y: begin
				mul_coef = b1_q;
				mul_val = x_q;
			end
			OP_N1A: begin
				mul_coef = a1_q;
				mul_val = y_q;
			end
			OP_N1B: begin
				mul_coef = b2_q;
				mul_val = x_q;
			end
			OP_N2A: begin
				mul_coef = a2_q;
				mul_val = y_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_res = mul_coef * mul_val;

	// Output sample: round half up, arithmetic shift, saturate to the sample range.
	assign y_sum = ACC_BITS'(prod_q) + ACC_BITS'(d1_q) + Y_RND;
	assign y_shift = y_sum >>> COEF_FRAC;
	assign y_sat = (y_shift > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] :
		(y_shift < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0] : y_shift[SAMPLE_BITS-1:0];

	assign st_diff = acc_q - ACC_BITS'(prod_q);
	assign st_sat = (st_diff > S_MAX) ? S_MAX[STATE_BITS-1:0] :
		(st_diff < S_MIN) ? S_MIN[STATE_BITS-1:0] : st_diff[STATE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			b0_q <= COEF_BITS'(1) << COEF_FRAC;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_B0: b0_q <= cfg_data[COEF_BITS-1:0];
				REG_B1: b1_q <= cfg_data[COEF_BITS-1:0];
				REG_B2: b2_q <= cfg_data[COEF_BITS-1:0];
				REG_A1: a1_q <= cfg_data[COEF_BITS-1:0];
				REG_A2: a2_q <= cfg_data[COEF_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (cmd.op == OP_N1B) begin
				d1_q <= st_sat;
			end
			if (cmd.op == OP_N2B) begin
				d2_q <= st_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q <= in_sample;
				y_q <= in_sample;
				last_q <= in_last;
			end
			OP_B0: prod_q <= mul_res;
			OP_Y: begin
				y_q <= y_sat;
				prod_q <= mul_res;
			end
			OP_N1A: begin
				acc_q <= ACC_BITS'(prod_q) + ACC_BITS'(d2_q);
				prod_q <= mul_res;
			end
			OP_N1B: prod_q <= mul_res;
			OP_N2A: begin
				acc_q <= ACC_BITS'(prod_q);
				prod_q <= mul_res;
			end
			OP_PUSH: begin
				out_q <= y_q;
				out_last_q <= last_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.filter_en = enable_q;
	assign out_tdata = TDATA_BITS'($unsigned(out_q));
	assign out_tlast = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/bqf_ctrl.sv =====
// Controller of the biquad filter: sequences the shared multiplier and the output handshake.
`default_nettype none

module bqf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_tvalid,
	output logic                  in_tready,
	output logic                  out_tvalid,
	input  wire logic             out_tready,
	input  wire bqf_pkg::dp_stat_t stat,
	output bqf_pkg::dp_cmd_t      cmd
);
	import bqf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B0,
		ST_Y,
		ST_N1A,
		ST_N1B,
		ST_N2A,
		ST_N2B,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_tready;

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			ST_IDLE: if (in_tvalid) cmd.op = OP_LOAD;
			ST_B0: cmd.op = OP_B0;
			ST_Y: cmd.op = OP_Y;
			ST_N1A: cmd.op = OP_N1A;
			ST_N1B: cmd.op = OP_N1B;
			ST_N2A: cmd.op = OP_N2A;
			ST_N2B: cmd.op = OP_N2B;
			ST_PUSH: if (slot_free) cmd.op = OP_PUSH;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUSH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_tvalid) begin
						state_q <= stat.filter_en ? ST_B0 : ST_PUSH;
					end
				end
				ST_B0: state_q <= ST_Y;
				ST_Y: state_q <= ST_N1A;
				ST_N1A: state_q <= ST_N1B;
				ST_N1B: state_q <= ST_N2A;
				ST_N2A: state_q <= ST_N2B;
				ST_N2B: state_q <= ST_PUSH;
				ST_PUSH: begin
					// The finished word moves into the output register once it is free.
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_tready = (state_q == ST_IDLE);
	assign out_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/biquad_tdf2_filter.sv =====
// Top level of the fixed-point transposed direct form II biquad filter.
// Each input word is one signed Q1.15 sample; each output word is the filtered sample,
// saturated to 16 bits. With enable set, a sample goes from acceptance to the output
// register through a single shared multiplier, which takes all five coefficient products
// in turn (five multiplier steps including the feedback products, then one step to close
// the second state and one to load the output register); a new sample is taken only
// after the last one has been loaded into the output register. With enable clear, a
// sample skips the multiplier steps and goes straight to the step that loads the
// output register. A stalled output holds the controller in its last step until the
// register is free. The output register holds a finished word while the next sample is
// accepted and worked on. The user must write coefficients through the configuration
// port only while no sample is in flight; the block itself does not enforce this.
`default_nettype none

module biquad_tdf2_filter (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bqf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bqf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [bqf_pkg::TDATA_BITS-1:0]     s_axis_tdata,  // sample_in
	input  wire logic                               s_axis_tlast,  // last_in
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [bqf_pkg::TDATA_BITS-1:0]          m_axis_tdata,  // sample_out
	output logic                                    m_axis_tlast   // last_out
);
	import bqf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bqf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bqf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_tdata (m_axis_tdata),
		.out_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/core/bqf_checker.sv =====
// Port-level checks of the biquad filter and the bind that attaches them.
`default_nettype none

module bqf_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [bqf_pkg::TDATA_BITS-1:0] m_axis_tdata
);
	import bqf_pkg::*;

	logic in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed or dropped while stalled");

	// Only one sample is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input accepted while a sample is being processed");

	// Valid never rises at the edge that accepts a sample; even a bypass passes through the push step first.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(m_axis_tvalid))
		else $error("output word appeared one cycle after acceptance");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("handshake output is unknown");

endmodule

bind biquad_tdf2_filter bqf_checker u_bqf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/biquad_tdf2_filter_test.sv =====
// Self-checking stream testbench for the biquad TDF-II filter with a bit-exact predictor.
`timescale 1ns / 100ps

module biquad_tdf2_filter_test;

	import bqf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LO = CFG_INDEX_BITS'(6);
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI = CFG_INDEX_BITS'(7);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

	typedef struct {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last;
	} audio_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [TDATA_BITS-1:0]     s_axis_tdata = '0;
	logic                      s_axis_tlast = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [TDATA_BITS-1:0]     m_axis_tdata;
	logic                      m_axis_tlast;

	biquad_tdf2_filter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Predictor state: enable and coefficients mirrored from the writes the test makes, delays from the predicted samples.
	bit     filt_on = 1'b0;
	longint coef_b0 = longint'(COEF_ONE);
	longint coef_b1 = 0;
	longint coef_b2 = 0;
	longint coef_a1 = 0;
	longint coef_a2 = 0;
	longint delay_one = 0;
	longint delay_two = 0;

	audio_word_t sample_q[$];
	audio_word_t filtered_q[$];
	int          queued_cnt = 0;
	int          accepted_cnt = 0;
	int          err_cnt = 0;
	int          cycle_cnt = 0;
	bit          in_taken = 1'b0;
	bit          burst_mode = 1'b0;
	audio_word_t drv_word;
	audio_word_t got_word;
	audio_word_t exp_word;

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// One step of the filter; updates the delay states when filtering is on.
	function automatic logic [SAMPLE_BITS-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] raw);
		longint x;
		longint acc;
		longint y;
		longint n1;
		longint n2;
		x = longint'($signed(raw));
		if (!filt_on)
			return raw;
		acc = coef_b0 * x + delay_one + (longint'(1) <<< (COEF_FRAC - 1));
		y = clip(acc >>> COEF_FRAC, SAMPLE_BITS);
		n1 = coef_b1 * x - coef_a1 * y + delay_two;
		n2 = coef_b2 * x - coef_a2 * y;
		delay_one = clip(n1, STATE_BITS);
		delay_two = clip(n2, STATE_BITS);
		return y[SAMPLE_BITS-1:0];
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENABLE: filt_on = val[0];
			REG_B0: coef_b0 = longint'($signed(val[COEF_BITS-1:0]));
			REG_B1: coef_b1 = longint'($signed(val[COEF_BITS-1:0]));
			REG_B2: coef_b2 = longint'($signed(val[COEF_BITS-1:0]));
			REG_A1: coef_a1 = longint'($signed(val[COEF_BITS-1:0]));
			REG_A2: coef_a2 = longint'($signed(val[COEF_BITS-1:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_filter(input bit en, input logic [COEF_BITS-1:0] b0,
			input logic [COEF_BITS-1:0] b1, input logic [COEF_BITS-1:0] b2,
			input logic [COEF_BITS-1:0] a1, input logic [COEF_BITS-1:0] a2);
		// Spare bits of the enable write carry noise; only bit 0 counts.
		write_reg(REG_ENABLE, {CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(1)} | CFG_DATA_BITS'(en));
		write_reg(REG_B0, b0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		write_reg(REG_A1, a1);
		write_reg(REG_A2, a2);
	endtask

	task automatic queue_word(input logic [SAMPLE_BITS-1:0] sample, input logic last);
		audio_word_t w;
		w.sample = sample;
		w.last = last;
		sample_q.push_back(w);
		queued_cnt++;
	endtask

	task automatic queue_random(input int count);
		logic [SAMPLE_BITS-1:0] s;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(9);
			if (kind <= 5)
				s = SAMPLE_BITS'($urandom);
			else if (kind <= 7)
				s = SAMPLE_BITS'($urandom_range(2048) - 1024);
			else if (kind == 8)
				s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
			else
				s = '0;
			queue_word(s, $urandom_range(7) == 0);
		end
	endtask

	// Returns once every queued word went in and every result came back.
	task automatic wait_drained(input int extra);
		do
			@(negedge clk);
		while (accepted_cnt != queued_cnt || filtered_q.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	function automatic logic [COEF_BITS-1:0] pick_coef(input int mode);
		if (mode == 0)
			return COEF_BITS'($urandom);
		case ($urandom_range(3))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return COEF_ONE;
			default: return '0;
		endcase
	endfunction

	// Sender: a new word may go out only when the bus is empty or the last one was taken.
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_taken) begin
			if (arst_n && sample_q.size() != 0 && (burst_mode || $urandom_range(99) >= 31)) begin
				drv_word = sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= TDATA_BITS'(drv_word.sample);
				s_axis_tlast <= drv_word.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= burst_mode || ($urandom_range(99) >= 31);
	end

	// Output check comes first, then the accepted input word is predicted.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_word.sample = m_axis_tdata[SAMPLE_BITS-1:0];
				got_word.last = m_axis_tlast;
				if (filtered_q.size() == 0) begin
					$display("%0t: word with nothing expected, got sample %h last %b",
						$time, got_word.sample, got_word.last);
					err_cnt++;
				end else begin
					exp_word = filtered_q.pop_front();
					if (got_word.sample !== exp_word.sample) begin
						$display("%0t: sample_out mismatch, expected %h got %h",
							$time, exp_word.sample, got_word.sample);
						err_cnt++;
					end
					if (got_word.last !== exp_word.last) begin
						$display("%0t: last_out mismatch, expected %b got %b",
							$time, exp_word.last, got_word.last);
						err_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				in_taken = 1'b1;
				exp_word.sample = filter_sample(s_axis_tdata[SAMPLE_BITS-1:0]);
				exp_word.last = s_axis_tlast;
				filtered_q.push_back(exp_word);
				accepted_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int mode;
		logic [COEF_BITS-1:0] b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset state: filtering off, every sample passes through.
		@(posedge clk);
		queue_word(SAMPLE_MIN, 1'b0);
		queue_word(SAMPLE_MAX, 1'b1);
		queue_word('0, 1'b0);
		queue_word('1, 1'b0);
		queue_word(SAMPLE_BITS'(1), 1'b0);
		queue_word(SAMPLE_BITS'('h5555), 1'b1);
		queue_word(SAMPLE_BITS'('hAAAA), 1'b0);
		wait_drained(DRAIN_CYCLES);

		// Reset coefficients give unity gain once filtering is on.
		write_reg(REG_ENABLE, CFG_DATA_BITS'(1));
		@(posedge clk);
		queue_word(SAMPLE_MIN, 1'b0);
		queue_word(SAMPLE_MAX, 1'b0);
		queue_word(SAMPLE_BITS'(1), 1'b1);
		wait_drained(DRAIN_CYCLES);

		// Largest coefficients drive both the states and the output into saturation.
		set_filter(1'b1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
		@(posedge clk);
		queue_word(SAMPLE_MAX, 1'b0);
		queue_word(SAMPLE_MIN, 1'b0);
		queue_word(SAMPLE_MAX, 1'b0);
		queue_word(SAMPLE_MAX, 1'b0);
		queue_word(SAMPLE_MIN, 1'b1);
		wait_drained(DRAIN_CYCLES);

		// Bypass must leave the saturated states alone; the next run starts from them.
		write_reg(REG_ENABLE, CFG_DATA_BITS'(0));
		@(posedge clk);
		queue_word(SAMPLE_BITS'('h1234), 1'b0);
		queue_word(SAMPLE_MIN, 1'b1);
		wait_drained(DRAIN_CYCLES);
		write_reg(REG_UNUSED_LO, CFG_DATA_BITS'($urandom));
		write_reg(REG_UNUSED_HI, CFG_DATA_BITS'($urandom));
		set_filter(1'b1, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
		@(posedge clk);
		queue_word(SAMPLE_MIN, 1'b0);
		queue_word(SAMPLE_MAX, 1'b0);
		queue_word('0, 1'b0);
		queue_word('0, 1'b1);
		wait_drained(DRAIN_CYCLES);

		// Impulse into a resonant low-pass.
		set_filter(1'b1, COEF_BITS'(1024), COEF_BITS'(2048), COEF_BITS'(1024),
			COEF_BITS'(-30000), COEF_BITS'(14000));
		@(posedge clk);
		queue_word(SAMPLE_MAX, 1'b0);
		queue_word('0, 1'b0);
		queue_word('0, 1'b0);
		queue_word('0, 1'b1);
		wait_drained(DRAIN_CYCLES);

		for (int phase = 0; phase < 12; phase++) begin
			mode = $urandom_range(2);
			if (mode == 2) begin
				b0 = COEF_BITS'($urandom_range(4096));
				set_filter($urandom_range(4) != 0, b0, b0 << 1, b0,
					COEF_BITS'(-int'($urandom_range(32000, 16384))),
					COEF_BITS'($urandom_range(15000, 4096)));
			end else begin
				set_filter($urandom_range(4) != 0, pick_coef(mode), pick_coef(mode),
					pick_coef(mode), pick_coef(mode), pick_coef(mode));
			end
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
					CFG_DATA_BITS'($urandom));
			@(posedge clk);
			burst_mode = (phase == 3);
			if (phase == 6) begin
				// The sender holds off mid-run until every result is back.
				queue_random(31);
				wait_drained(0);
				@(posedge clk);
				queue_random(31);
			end else begin
				queue_random(62);
			end
			wait_drained(DRAIN_CYCLES);
		end

		burst_mode = 1'b0;
		wait_drained(20);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
